// ----- rtl/ckfsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfsp_pkg
// Types and fixed constants shared by the circular free slot placer.
// ----------------------------------------------------------------------------
package ckfsp_pkg;

  localparam int CARD_W    = 15;
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_QRD,
    S_QWT,
    S_CALC,
    S_DIV,
    S_FRD,
    S_FWT,
    S_URD,
    S_UWT
  } state_t;

endpackage

// ----- rtl/ckfsp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfsp_ram
// Generic simple dual port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ckfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/circular_kth_free_slot_placer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_kth_free_slot_placer
// Places cards one per transaction into a ring of slots kept in a Fenwick tree.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; new_deal and
// card are sampled then. The result (slot, placed_card, deal_done) is shown for
// one cycle with strobe high, and busy falls in the same cycle.
// The tree lives in one RAM of MAX_SLOTS entries. A transaction runs two
// prefix walks (up to one RAM read per bit of the slot index each), a
// remainder step when the count wraps, a tree descent and an update walk.
// When the ring is already full the result follows the two prefix walks alone.
// After reset and at every transaction with new_deal set, the RAM is cleared
// one entry per cycle, with busy high. The deck_size register may be written
// at any time the block is idle and is cleared to 16384 by reset. The
// receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module circular_kth_free_slot_placer #(
  parameter int MAX_SLOTS = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          deck_size_we,
  input  logic [ckfsp_pkg::CARD_W-1:0]  deck_size,
  input  logic                          start,
  output logic                          busy,
  input  logic                          new_deal,
  input  logic [ckfsp_pkg::CARD_W-1:0]  card,
  output logic                          strobe,
  output logic [ckfsp_pkg::CARD_W-1:0]  slot,
  output logic [ckfsp_pkg::CARD_W-1:0]  placed_card,
  output logic                          deal_done
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int AW = $clog2(MAX_SLOTS);
  localparam int VW = ((CW > ckfsp_pkg::DIV_W) ? CW : ckfsp_pkg::DIV_W) + 2;

  ckfsp_pkg::state_t state, state_next;

  logic [ckfsp_pkg::CARD_W-1:0]  deck_r;
  logic [AW-1:0]                 clr_addr;
  logic                          pend;
  logic                          phase;
  logic [CW-1:0]                 cur;
  logic [CW-1:0]                 n_r;
  logic [CW-1:0]                 p_r;
  logic [CW-1:0]                 qx;
  logic [VW-1:0]                 acc;
  logic [VW-1:0]                 used_p;
  logic [VW-1:0]                 tf_r;
  logic [ckfsp_pkg::DIV_W-1:0]   dvd;
  logic [VW-1:0]                 div_rem;
  logic [ckfsp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [VW-1:0]                 rem_t;
  logic [CW-1:0]                 pos;
  logic [CW-1:0]                 step;
  logic [CW:0]                   ux;
  logic [CW-1:0]                 x_r;
  logic [ckfsp_pkg::CARD_W-1:0]  card_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  logic [VW-1:0] n_v, cur_v, fb, tf, fa, need, r2, r_new, probe, cand;
  logic          accept;

  assign accept = start && !busy;

  always_comb begin
    if (deck_r == '0) begin
      n_v = VW'(1);
    end else if (VW'(deck_r) > VW'(MAX_SLOTS)) begin
      n_v = VW'(MAX_SLOTS);
    end else begin
      n_v = VW'(deck_r);
    end
    cur_v = new_deal ? '0 : VW'(cur);
    fb    = VW'(p_r) - used_p;
    tf    = VW'(n_r) - acc;
    fa    = tf - fb;
    need  = VW'(card_r) + VW'(1);
    r2    = {div_rem[VW-2:0], dvd[ckfsp_pkg::DIV_W-1]};
    r_new = (r2 >= tf_r) ? r2 - tf_r : r2;
    probe = VW'(pos) + VW'(step);
    cand  = VW'(step) - VW'(ram_rdata);
  end

  ckfsp_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_SLOTS)
  ) u_tree (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ckfsp_pkg::S_CLEAR: begin
        if (clr_addr == AW'(MAX_SLOTS - 1)) begin
          state_next = pend ? ckfsp_pkg::S_QRD : ckfsp_pkg::S_IDLE;
        end
      end
      ckfsp_pkg::S_IDLE: begin
        if (start) begin
          state_next = new_deal ? ckfsp_pkg::S_CLEAR : ckfsp_pkg::S_QRD;
        end
      end
      ckfsp_pkg::S_QRD: begin
        if (qx != '0) begin
          state_next = ckfsp_pkg::S_QWT;
        end else if (phase) begin
          state_next = ckfsp_pkg::S_CALC;
        end
      end
      ckfsp_pkg::S_QWT: state_next = ckfsp_pkg::S_QRD;
      ckfsp_pkg::S_CALC: begin
        if (tf == '0) begin
          state_next = ckfsp_pkg::S_IDLE;
        end else if (need <= fa) begin
          state_next = ckfsp_pkg::S_FRD;
        end else begin
          state_next = ckfsp_pkg::S_DIV;
        end
      end
      ckfsp_pkg::S_DIV: begin
        if (div_cnt == ckfsp_pkg::DIV_CNT_W'(ckfsp_pkg::DIV_W - 1)) begin
          state_next = ckfsp_pkg::S_FRD;
        end
      end
      ckfsp_pkg::S_FRD: begin
        if (step == '0) begin
          state_next = ckfsp_pkg::S_URD;
        end else if (probe <= VW'(MAX_SLOTS)) begin
          state_next = ckfsp_pkg::S_FWT;
        end
      end
      ckfsp_pkg::S_FWT: state_next = ckfsp_pkg::S_FRD;
      ckfsp_pkg::S_URD: begin
        if ((CW + 1)'(ux) > (CW + 1)'(MAX_SLOTS)) begin
          state_next = ckfsp_pkg::S_IDLE;
        end else begin
          state_next = ckfsp_pkg::S_UWT;
        end
      end
      ckfsp_pkg::S_UWT: state_next = ckfsp_pkg::S_URD;
      default: state_next = ckfsp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ckfsp_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = AW'(qx - CW'(1));
    case (state)
      ckfsp_pkg::S_CLEAR: ram_we = 1'b1;
      ckfsp_pkg::S_FRD:   ram_raddr = AW'(probe - VW'(1));
      ckfsp_pkg::S_URD:   ram_raddr = AW'(ux - (CW + 1)'(1));
      ckfsp_pkg::S_UWT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ux - (CW + 1)'(1));
        ram_wdata = ram_rdata + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ckfsp_pkg::S_CLEAR;
      deck_r   <= ckfsp_pkg::CARD_W'(16384);
      clr_addr <= '0;
      pend     <= 1'b0;
      cur      <= '0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (deck_size_we) begin
        deck_r <= deck_size;
      end
      case (state)
        ckfsp_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_SLOTS - 1)) begin
            clr_addr <= '0;
            pend     <= 1'b0;
          end
        end
        ckfsp_pkg::S_IDLE: begin
          if (accept) begin
            card_r <= card;
            n_r    <= CW'(n_v);
            p_r    <= (cur_v < n_v) ? CW'(cur_v) : CW'(n_v);
            qx     <= (cur_v < n_v) ? CW'(cur_v) : CW'(n_v);
            acc    <= '0;
            phase  <= 1'b0;
            pend   <= new_deal;
            if (new_deal) begin
              cur <= '0;
            end
          end
        end
        ckfsp_pkg::S_QRD: begin
          if (qx == '0 && !phase) begin
            used_p <= acc;
            acc    <= '0;
            qx     <= n_r;
            phase  <= 1'b1;
          end
        end
        ckfsp_pkg::S_QWT: begin
          acc <= acc + VW'(ram_rdata);
          qx  <= qx & (qx - CW'(1));
        end
        ckfsp_pkg::S_CALC: begin
          tf_r        <= tf;
          placed_card <= card_r;
          pos         <= '0;
          step        <= CW'(1) << (CW - 1);
          rem_t       <= fb + need;
          dvd         <= ckfsp_pkg::DIV_W'(need - fa);
          div_rem     <= '0;
          div_cnt     <= '0;
          if (tf == '0) begin
            strobe    <= 1'b1;
            slot      <= '0;
            deal_done <= 1'b1;
          end
        end
        ckfsp_pkg::S_DIV: begin
          div_rem <= r_new;
          dvd     <= {dvd[ckfsp_pkg::DIV_W-2:0], 1'b0};
          div_cnt <= div_cnt + ckfsp_pkg::DIV_CNT_W'(1);
          if (div_cnt == ckfsp_pkg::DIV_CNT_W'(ckfsp_pkg::DIV_W - 1)) begin
            rem_t <= (r_new == '0) ? tf_r : r_new;
          end
        end
        ckfsp_pkg::S_FRD: begin
          if (step == '0) begin
            x_r <= pos + CW'(1);
            ux  <= (CW + 1)'(pos) + (CW + 1)'(1);
          end else if (probe > VW'(MAX_SLOTS)) begin
            step <= step >> 1;
          end
        end
        ckfsp_pkg::S_FWT: begin
          if (cand < rem_t) begin
            pos   <= CW'(probe);
            rem_t <= rem_t - cand;
          end
          step <= step >> 1;
        end
        ckfsp_pkg::S_URD: begin
          if ((CW + 1)'(ux) > (CW + 1)'(MAX_SLOTS)) begin
            strobe    <= 1'b1;
            slot      <= ckfsp_pkg::CARD_W'(VW'(x_r));
            deal_done <= (tf_r == VW'(1));
            cur       <= x_r;
          end
        end
        ckfsp_pkg::S_UWT: begin
          ux <= ux + (ux & (~ux + (CW + 1)'(1)));
        end
        default: ;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("Result strobe lasted more than one cycle.");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("Result appeared without a transaction in progress.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Busy did not rise after an accepted transaction.");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ckfsp_pkg::S_CLEAR) |-> (busy && !strobe))
    else $error("Clearing pass overlapped a result or idle state.");

endmodule

// ----- tb/sv/tb_circular_kth_free_slot_placer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_kth_free_slot_placer
// Self-checking testbench for the circular free slot placer.
// ----------------------------------------------------------------------------
// A directed table covers reset values, deck size extremes, full rings and
// out-of-order cards. It is followed by random deals that mostly place cards
// in order. Each result is checked against a slot occupancy model kept in the
// testbench.
// ----------------------------------------------------------------------------
module tb_circular_kth_free_slot_placer;

  localparam int CARD_W = ckfsp_pkg::CARD_W;
  localparam int NSLOTS = 16384;

  typedef struct {
    logic [CARD_W-1:0] slot;
    logic [CARD_W-1:0] card;
    logic              done;
  } placement_t;

  typedef struct {
    bit                is_cfg;
    logic [CARD_W-1:0] value;
    bit                deal;
    logic [CARD_W-1:0] card;
    int                want_slot;
    int                want_done;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic deck_size_we = 1'b0;
  logic [CARD_W-1:0] deck_size = '0;
  logic start = 1'b0;
  logic busy;
  logic new_deal = 1'b0;
  logic [CARD_W-1:0] card = '0;
  logic strobe;
  logic [CARD_W-1:0] slot;
  logic [CARD_W-1:0] placed_card;
  logic deal_done;

  bit taken [1:NSLOTS];
  int cur_slot;
  int deck_reg = NSLOTS;
  placement_t placements_due[$];
  int mismatches = 0;
  int transactions = 0;
  int deals = 0;
  int full_hits = 0;
  int idle_pct = 0;

  circular_kth_free_slot_placer dut (
    .clk(clk), .rst(rst), .deck_size_we(deck_size_we), .deck_size(deck_size),
    .start(start), .busy(busy), .new_deal(new_deal), .card(card),
    .strobe(strobe), .slot(slot), .placed_card(placed_card), .deal_done(deal_done)
  );

  always #6 clk = ~clk;

  function automatic placement_t place_card(bit deal, logic [CARD_W-1:0] c);
    placement_t r;
    int n, p, free_before, total_free, free_after, need, target, cnt, x;
    n = deck_reg < 1 ? 1 : (deck_reg > NSLOTS ? NSLOTS : deck_reg);
    if (deal) begin
      foreach (taken[i]) taken[i] = 0;
      cur_slot = 0;
    end
    p = cur_slot < n ? cur_slot : n;
    free_before = 0;
    total_free = 0;
    for (int i = 1; i <= n; i++) begin
      if (!taken[i]) begin
        total_free++;
        if (i <= p) free_before++;
      end
    end
    r.card = c;
    if (total_free == 0) begin
      r.slot = '0;
      r.done = 1'b1;
      return r;
    end
    free_after = total_free - free_before;
    need = int'(c) + 1;
    if (need <= free_after) target = free_before + need;
    else begin
      target = (need - free_after) % total_free;
      if (target == 0) target = total_free;
    end
    cnt = 0;
    x = n;
    for (int i = 1; i <= n; i++) begin
      if (!taken[i]) cnt++;
      if (cnt >= target) begin
        x = i;
        break;
      end
    end
    taken[x] = 1;
    cur_slot = x;
    r.slot = x[CARD_W-1:0];
    r.done = (total_free == 1);
    return r;
  endfunction

  task automatic write_deck(logic [CARD_W-1:0] v);
    start <= 1'b0;
    while (placements_due.size() != 0 || busy) @(posedge clk);
    deck_size_we <= 1'b1;
    deck_size <= v;
    @(posedge clk);
    deck_size_we <= 1'b0;
    deck_reg = v;
  endtask

  task automatic place(bit deal, logic [CARD_W-1:0] c, int want_slot, int want_done);
    placement_t e;
    int gap;
    start <= 1'b1;
    new_deal <= deal;
    card <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = place_card(deal, c);
    if (want_slot >= 0 && (e.slot != want_slot || e.done != want_done)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row for card %0d: expected slot %0d done %0d, model %0d %0d",
                 c, want_slot, want_done, e.slot, e.done);
    end
    placements_due.insert(placements_due.size(), e);
    transactions++;
    if (deal) deals++;
    if (e.slot == 0) full_hits++;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    placement_t e;
    if (!rst && strobe) begin
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: slot %0d card %0d", slot, placed_card);
      end else begin
        e = placements_due.pop_front();
        if (slot !== e.slot || placed_card !== e.card || deal_done !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slot %0d card %0d done %0d, got %0d %0d %0d",
                     e.slot, e.card, e.done, slot, placed_card, deal_done);
        end
      end
    end
  end

  row_t steps[$];

  function automatic void add_row(row_t r);
    steps.insert(steps.size(), r);
  endfunction

  function automatic row_t cfg_row(int v);
    row_t r;
    r = '{1, v[CARD_W-1:0], 0, '0, -1, -1};
    return r;
  endfunction

  function automatic row_t card_row(bit d, int c, int s, int dn);
    row_t r;
    r = '{0, '0, d, c[CARD_W-1:0], s, dn};
    return r;
  endfunction

  initial begin
    int left, n, len;
    add_row(card_row(0, 1, 2, 0));
    add_row(cfg_row(1));
    add_row(card_row(1, 1, 1, 1));
    add_row(card_row(0, 5, 0, 1));
    add_row(cfg_row(0));
    add_row(card_row(1, 0, 1, 1));
    add_row(cfg_row(5));
    for (int c = 1; c <= 5; c++) add_row(card_row(c == 1, c, -1, -1));
    add_row(card_row(0, 3, 0, 1));
    add_row(card_row(0, 32767, 0, 1));
    add_row(cfg_row(32767));
    add_row(card_row(1, 32767, -1, -1));
    add_row(card_row(0, 16384, -1, -1));
    add_row(cfg_row(3));
    add_row(card_row(0, 1, -1, -1));
    add_row(card_row(0, 2, -1, -1));
    add_row(cfg_row(16384));
    add_row(card_row(0, 1, -1, -1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (taken[i]) taken[i] = 0;
    cur_slot = 0;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_deck(steps[i].value);
      else place(steps[i].deal, steps[i].card, steps[i].want_slot, steps[i].want_done);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 14 : (ph == 1 ? 46 : 0);
      left = 410;
      while (left > 0) begin
        case ($urandom_range(9))
          0: n = $urandom_range(3, 1);
          1: n = 16384;
          2: n = $urandom_range(32767, 16385);
          3: n = 0;
          default: n = $urandom_range(40, 1);
        endcase
        write_deck(n[CARD_W-1:0]);
        len = (n < 1) ? 1 : (n > 40 ? $urandom_range(30, 5) : n);
        len += ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
        for (int c = 1; c <= len && left > 0; c++) begin
          place(c == 1, ($urandom_range(9) < 8) ? c[CARD_W-1:0]
                                                : CARD_W'($urandom_range(32767)), -1, -1);
          left--;
        end
      end
    end

    start <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions over %0d deals, %0d on a full ring",
             transactions, deals, full_hits);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
